### rtl/core/rc4iv_pkg.sv
// Package for the RC4 cipher with IV-mixed key schedule.
// Holds the sizes, the register index codes and the controller state encoding.
// No dependencies.
package rc4iv_pkg;

   localparam int MAX_KEY_BYTES = 32;
   localparam int IV_BYTES      = 16;
   localparam int KEY_WORDS     = 4;
   localparam int IV_WORDS      = 2;
   localparam int WORD_W        = 64;
   localparam int BYTE_W        = 8;
   localparam int PERM_DEPTH    = 256;
   localparam int KLEN_W        = 6;
   localparam int KIDX_W        = $clog2(MAX_KEY_BYTES);
   localparam int IVIDX_W       = $clog2(IV_BYTES);
   localparam int CSR_IDX_W     = 3;

   localparam logic [KLEN_W-1:0] KEY_LEN_RESET = KLEN_W'(MAX_KEY_BYTES);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY0    = 3'd0,
      CSR_KEY1    = 3'd1,
      CSR_KEY2    = 3'd2,
      CSR_KEY3    = 3'd3,
      CSR_IV0     = 3'd4,
      CSR_IV1     = 3'd5,
      CSR_KEY_LEN = 3'd6
   } csr_index_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_FILL  = 6'b000010,
      ST_SCH_J = 6'b000100,
      ST_SCH_W = 6'b001000,
      ST_KADDR = 6'b010000,
      ST_SWAP  = 6'b100000
   } state_type;

endpackage

### rtl/core/rc4_iv_stream_cipher.sv
// RC4 stream cipher with a key schedule that also mixes in a 16-byte IV.
// Holds the permutation memory, the schedule sequencer and the stream ports.
// Depends on rc4iv_pkg.

// One data byte enters per transfer on req_ and leaves XORed with the next
// keystream byte on rsp_, one result per byte, in order. The permutation lives in
// a 256 x 8 memory with two registered read ports and one write port. A byte that
// continues the stream runs in order: read S[i], then read S[k] while writing
// S[k], then read S[S[i]+S[k]] while writing S[i]; the keystream byte is
// registered into rsp_ in the cycle the next byte may already be taken. No new
// byte is taken while one is in that sequence or its keystream byte waits for a
// full rsp_ slot; the sequence on the single write port sets the rate. A byte
// with tuser set (start of buffer) first rebuilds the permutation: it writes the
// identity, then does the 256 key schedule swaps. Key, IV and key length
// registers must be written over csr_ only while no byte is in flight; the block
// itself does not enforce this. They take effect at the next buffer start. A key
// length of zero acts as one, lengths above 32 act as 32. Streaming before the
// first buffer start reads an unwritten permutation and gives undefined bytes.
module rc4_iv_stream_cipher (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: [7:0] data_byte
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,
   // req_tuser: [0] start_of_buffer
   input  logic                           req_tuser,
   // rsp_tdata: [7:0] out_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rc4iv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rc4iv_pkg::WORD_W-1:0]    csr_data
);
   import rc4iv_pkg::*;

   // configuration registers
   logic [WORD_W-1:0] key_ff [KEY_WORDS];
   logic [WORD_W-1:0] iv_ff  [IV_WORDS];
   logic [KLEN_W-1:0] key_len_ff;

   // permutation memory and its read ports
   logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
   logic              mem_we;
   logic [BYTE_W-1:0] mem_waddr;
   logic [BYTE_W-1:0] mem_wdata;
   logic              rd_en_a;
   logic              rd_en_b;
   logic [BYTE_W-1:0] addr_a;
   logic [BYTE_W-1:0] addr_b;
   logic [BYTE_W-1:0] rd_a_ff;
   logic [BYTE_W-1:0] rd_b_ff;

   // control and datapath registers
   state_type         state_ff, state_in;
   logic [BYTE_W-1:0] p_ff, p_in;
   logic [BYTE_W-1:0] j_ff, j_in;
   logic [BYTE_W-1:0] i_ff, i_in;
   logic [BYTE_W-1:0] k_ff, k_in;
   logic [KIDX_W-1:0]  kidx_ff, kidx_in;
   logic [IVIDX_W-1:0] ividx_ff, ividx_in;
   logic [BYTE_W-1:0] si_ff, si_in;
   logic [BYTE_W-1:0] sk_ff, sk_in;
   logic              fwd_ff, fwd_in;
   logic              pend_ff, pend_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;

   logic              req_fire;
   logic              slot_free;
   logic              capture;
   logic [KLEN_W-1:0] len_eff;
   logic [BYTE_W-1:0] key_byte;
   logic [BYTE_W-1:0] iv_byte;
   logic [BYTE_W-1:0] ks_byte;
   logic [BYTE_W-1:0] sum_j;
   logic [BYTE_W-1:0] sum_k;
   logic [BYTE_W-1:0] sum_t;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Output slot is free when empty or drained this cycle; another byte is taken
   // only when a pending keystream byte can land in it in the same cycle.
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && (!pend_ff || slot_free);
   assign req_fire   = req_tvalid && req_tready;
   assign capture    = (state_ff == ST_IDLE) && pend_ff && slot_free;

   // Clamp the key length to 1..MAX_KEY_BYTES.
   always_comb begin
      if (key_len_ff == '0) begin
         len_eff = KLEN_W'(1);
      end else if (key_len_ff > KLEN_W'(MAX_KEY_BYTES)) begin
         len_eff = KLEN_W'(MAX_KEY_BYTES);
      end else begin
         len_eff = key_len_ff;
      end
   end

   assign key_byte = key_ff[kidx_ff[KIDX_W-1:3]][kidx_ff[2:0]*BYTE_W +: BYTE_W];
   assign iv_byte  = iv_ff[ividx_ff[IVIDX_W-1:3]][ividx_ff[2:0]*BYTE_W +: BYTE_W];

   // When the final lookup hit S[i], the memory still held the pre-swap value.
   assign ks_byte = fwd_ff ? sk_ff : rd_a_ff;

   assign sum_j = j_ff + rd_a_ff + key_byte + iv_byte;
   assign sum_k = k_ff + rd_a_ff;
   assign sum_t = si_ff + rd_b_ff;

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      j_in         = j_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      kidx_in      = kidx_ff;
      ividx_in     = ividx_ff;
      si_in        = si_ff;
      sk_in        = sk_ff;
      fwd_in       = fwd_ff;
      pend_in      = pend_ff;
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = p_ff;
      mem_wdata    = p_ff;
      rd_en_a      = 1'b0;
      addr_a       = p_ff;
      rd_en_b      = 1'b0;
      addr_b       = sum_k;

      if (capture) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = data_ff ^ ks_byte;
         pend_in      = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               data_in = req_tdata;
               if (req_tuser) begin
                  p_in     = '0;
                  state_in = ST_FILL;
               end else begin
                  // fetch S[i+1]
                  rd_en_a  = 1'b1;
                  addr_a   = i_ff + 8'd1;
                  i_in     = i_ff + 8'd1;
                  state_in = ST_KADDR;
               end
            end
         end
         ST_FILL: begin
            // write the identity, then fetch S[0] for the first swap
            mem_we    = 1'b1;
            mem_waddr = p_ff;
            mem_wdata = p_ff;
            p_in      = p_ff + 8'd1;
            if (p_ff == 8'(PERM_DEPTH - 1)) begin
               rd_en_a  = 1'b1;
               addr_a   = '0;
               j_in     = '0;
               kidx_in  = '0;
               ividx_in = '0;
               state_in = ST_SCH_J;
            end
         end
         ST_SCH_J: begin
            // new j; read old S[j] and write S[j] <= S[p] in the same cycle
            j_in      = sum_j;
            rd_en_b   = 1'b1;
            addr_b    = sum_j;
            mem_we    = 1'b1;
            mem_waddr = sum_j;
            mem_wdata = rd_a_ff;
            state_in  = ST_SCH_W;
         end
         ST_SCH_W: begin
            // complete the swap: S[p] <= old S[j]
            mem_we    = 1'b1;
            mem_waddr = p_ff;
            mem_wdata = rd_b_ff;
            p_in      = p_ff + 8'd1;
            if ({1'b0, kidx_ff} == len_eff - KLEN_W'(1)) begin
               kidx_in = '0;
            end else begin
               kidx_in = kidx_ff + KIDX_W'(1);
            end
            if (ividx_ff == IVIDX_W'(IV_BYTES - 1)) begin
               ividx_in = '0;
            end else begin
               ividx_in = ividx_ff + IVIDX_W'(1);
            end
            rd_en_a = 1'b1;
            if (p_ff == 8'(PERM_DEPTH - 1)) begin
               // schedule done: clear k, start generation at i = 1
               addr_a   = 8'd1;
               i_in     = 8'd1;
               k_in     = '0;
               state_in = ST_KADDR;
            end else begin
               addr_a   = p_ff + 8'd1;
               state_in = ST_SCH_J;
            end
         end
         ST_KADDR: begin
            // k += S[i]; read old S[k] and write S[k] <= S[i]
            k_in      = sum_k;
            si_in     = rd_a_ff;
            rd_en_b   = 1'b1;
            addr_b    = sum_k;
            mem_we    = 1'b1;
            mem_waddr = sum_k;
            mem_wdata = rd_a_ff;
            state_in  = ST_SWAP;
         end
         ST_SWAP: begin
            // S[i] <= old S[k]; look up the keystream byte
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = rd_b_ff;
            rd_en_a   = 1'b1;
            addr_a    = sum_t;
            sk_in     = rd_b_ff;
            fwd_in    = (sum_t == i_ff);
            pend_in   = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // permutation memory: one write port, two registered read ports (read-old)
   always_ff @(posedge clock) begin
      if (mem_we) begin
         perm_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en_a) begin
         rd_a_ff <= perm_mem[addr_a];
      end
      if (rd_en_b) begin
         rd_b_ff <= perm_mem[addr_b];
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < KEY_WORDS; w++) begin
            key_ff[w] <= '0;
         end
         for (int w = 0; w < IV_WORDS; w++) begin
            iv_ff[w] <= '0;
         end
         key_len_ff <= KEY_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index) inside
            [CSR_KEY0:CSR_KEY3]: begin
               key_ff[csr_index[1:0]] <= csr_data;
            end
            CSR_IV0: begin
               iv_ff[0] <= csr_data;
            end
            CSR_IV1: begin
               iv_ff[1] <= csr_data;
            end
            CSR_KEY_LEN: begin
               key_len_ff <= csr_data[KLEN_W-1:0];
            end
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         k_ff         <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         k_ff         <= k_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      j_ff        <= j_in;
      kidx_ff     <= kidx_in;
      ividx_ff    <= ividx_in;
      si_ff       <= si_in;
      sk_ff       <= sk_in;
      fwd_ff      <= fwd_in;
      data_ff     <= data_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### dv/rc4_iv_stream_cipher_test.sv
// Self-checking testbench for rc4_iv_stream_cipher: byte stream in, XORed bytes out.
// Carries its own keystream predictor and compares every output transfer in order.
// Depends on rc4iv_pkg and the rc4_iv_stream_cipher RTL.
module rc4_iv_stream_cipher_test;
   import rc4iv_pkg::*;

   localparam int CYCLE_LIMIT   = 400_000;
   localparam int END_QUIET     = 20;
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_COUNT   = 6;

   typedef struct packed {
      logic       start_of_buffer;
      logic [7:0] data_byte;
   } cipher_byte_type;

   // Clock and reset; reset is asserted from time zero, then released for good.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   // Every block input starts from a known value.
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [WORD_W-1:0]    csr_data   = '0;

   rc4_iv_stream_cipher dut (
      .clock      (clock),
      .reset      (reset),
      // req_tdata: [7:0] data_byte
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      // req_tuser: [0] start_of_buffer
      .req_tuser  (req_tuser),
      // rsp_tdata: [7:0] out_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Bytes waiting to be offered, and cipher bytes predicted but not yet seen.
   cipher_byte_type pending_bytes[$];
   logic [7:0]      expected_out_bytes[$];

   // Set at the rising edge of a request transfer, consumed by the driver.
   bit req_taken = 1'b0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int failures        = 0;
   int bytes_sent      = 0;
   int buffer_starts   = 0;
   int results_checked = 0;
   int cycle_count     = 0;

   // Predictor state: its own copy of the register file and of the cipher state.
   logic [WORD_W-1:0] key_cfg [KEY_WORDS];
   logic [WORD_W-1:0] iv_cfg  [IV_WORDS];
   logic [KLEN_W-1:0] key_len_cfg = KEY_LEN_RESET;
   logic [7:0]        sbox [PERM_DEPTH];
   logic [7:0]        pos_i = '0;
   logic [7:0]        pos_k = '0;

   initial begin
      foreach (key_cfg[w]) key_cfg[w] = '0;
      foreach (iv_cfg[w])  iv_cfg[w]  = '0;
   end

   // Compute the cipher byte for one input transfer. A buffer start rebuilds
   // the permutation with the key and IV mixed into the swap index, then
   // clears both stream indices before the generation step.
   function automatic logic [7:0] keystream_xor(input logic [7:0] data_byte,
                                                input logic restart);
      int         len;
      int         kpos;
      int         ipos;
      logic [7:0] j;
      logic [7:0] held;
      logic [7:0] ks;
      if (restart) begin
         // Zero length acts as one; anything past the key size saturates.
         len = (key_len_cfg == 0) ? 1 :
               (key_len_cfg > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(key_len_cfg);
         for (int p = 0; p < PERM_DEPTH; p++) sbox[p] = 8'(p);
         j = '0;
         for (int p = 0; p < PERM_DEPTH; p++) begin
            kpos = p % len;
            ipos = p % IV_BYTES;
            j = j + sbox[p] + key_cfg[kpos / 8][(kpos % 8) * 8 +: 8]
                  + iv_cfg[ipos / 8][(ipos % 8) * 8 +: 8];
            held    = sbox[p];
            sbox[p] = sbox[j];
            sbox[j] = held;
         end
         pos_i = '0;
         pos_k = '0;
      end
      pos_i       = pos_i + 8'd1;
      pos_k       = pos_k + sbox[pos_i];
      held        = sbox[pos_i];
      sbox[pos_i] = sbox[pos_k];
      sbox[pos_k] = held;
      ks = sbox[8'(sbox[pos_i] + sbox[pos_k])];
      return data_byte ^ ks;
   endfunction

   task automatic note_failure(input string what);
      failures++;
      if (failures <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Monitor: check output transfers first, then record the request transfer
   // and predict its result. The block cannot answer in the same cycle.
   always @(posedge clock) begin : observe
      logic [7:0] want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_out_bytes.size() == 0) begin
               note_failure($sformatf("unexpected out_byte 0x%02h", rsp_tdata));
            end else begin
               want = expected_out_bytes.pop_front();
               results_checked++;
               if (rsp_tdata !== want)
                  note_failure($sformatf("out_byte expected 0x%02h actual 0x%02h",
                                         want, rsp_tdata));
            end
         end
         if (req_tvalid && req_tready) begin
            expected_out_bytes.push_back(keystream_xor(req_tdata, req_tuser));
            bytes_sent++;
            if (req_tuser) buffer_starts++;
            req_taken = 1'b1;
         end
      end
   end

   // Driver: move on at the falling edge. Hold an offered byte until its
   // transfer, then draw the next one or idle; stall the output at random.
   always @(negedge clock) begin : drive
      bit taken;
      bit offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         taken = req_taken;
         if (taken) begin
            pending_bytes.delete(0);
            req_taken = 1'b0;
         end
         if (!req_tvalid || taken) begin
            offer = (pending_bytes.size() != 0) &&
                    ($urandom_range(99) >= send_idle_pct);
            req_tvalid <= offer;
            if (offer) begin
               req_tdata <= pending_bytes[0].data_byte;
               req_tuser <= pending_bytes[0].start_of_buffer;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: give up on a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_out_bytes.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Write one register and mirror it into the predictor on its transfer.
   task automatic write_csr(input csr_index_type idx, input logic [WORD_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_KEY0:    key_cfg[0]  = value;
         CSR_KEY1:    key_cfg[1]  = value;
         CSR_KEY2:    key_cfg[2]  = value;
         CSR_KEY3:    key_cfg[3]  = value;
         CSR_IV0:     iv_cfg[0]   = value;
         CSR_IV1:     iv_cfg[1]   = value;
         CSR_KEY_LEN: key_len_cfg = value[KLEN_W-1:0];
         default:     ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Load a full register set for one phase: random material by default,
   // all ones and all zeros at the extremes, and every key length corner.
   task automatic program_phase(input int phase);
      logic [WORD_W-1:0] kw [KEY_WORDS];
      logic [WORD_W-1:0] ivw [IV_WORDS];
      logic [KLEN_W-1:0] len;
      foreach (kw[w])  kw[w]  = {$urandom, $urandom};
      foreach (ivw[w]) ivw[w] = {$urandom, $urandom};
      len = KLEN_W'(MAX_KEY_BYTES);
      case (phase)
         1: begin
            foreach (kw[w])  kw[w]  = '1;
            foreach (ivw[w]) ivw[w] = '1;
            len = '0;  // zero length acts as one
         end
         2: begin
            foreach (kw[w])  kw[w]  = '0;
            foreach (ivw[w]) ivw[w] = '0;
            len = '1;  // far past the key size, saturates
         end
         3: len = KLEN_W'(1);
         4: len = KLEN_W'($urandom_range(2, MAX_KEY_BYTES - 1));
         5: len = KLEN_W'($urandom_range(0, (1 << KLEN_W) - 1));
         default: ;
      endcase
      write_csr(CSR_KEY0, kw[0]);
      write_csr(CSR_KEY1, kw[1]);
      write_csr(CSR_KEY2, kw[2]);
      write_csr(CSR_KEY3, kw[3]);
      write_csr(CSR_IV0, ivw[0]);
      write_csr(CSR_IV1, ivw[1]);
      write_csr(CSR_KEY_LEN, WORD_W'(len));
   endtask

   task automatic push_byte(input logic restart, input logic [7:0] data_byte);
      cipher_byte_type item;
      item.start_of_buffer = restart;
      item.data_byte       = data_byte;
      pending_bytes.push_back(item);
   endtask

   // Queue one buffer: a start byte (or a stream continuation) and random content.
   task automatic queue_buffer(input logic restart, input int length);
      for (int n = 0; n < length; n++)
         push_byte(restart && (n == 0), 8'($urandom_range(0, 255)));
   endtask

   task automatic wait_drained;
      while (pending_bytes.size() != 0 || expected_out_bytes.size() != 0)
         @(posedge clock);
   endtask

   initial begin : stimulus
      int queued;
      int len;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // Receiver-heavy idling first, sender-heavy next, then full rate.
         if (phase < 2) begin
            send_idle_pct = 29;
            recv_idle_pct = 66;
         end else if (phase < 4) begin
            send_idle_pct = 66;
            recv_idle_pct = 29;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         program_phase(phase);

         queued = 0;
         if (phase == 0) begin
            // Data extremes, restart mid-stream and back-to-back buffer starts.
            push_byte(1'b1, 8'h00);
            push_byte(1'b0, 8'hFF);
            push_byte(1'b0, 8'h00);
            push_byte(1'b0, 8'h55);
            push_byte(1'b0, 8'hAA);
            push_byte(1'b1, 8'hFF);
            push_byte(1'b1, 8'h00);
            push_byte(1'b1, 8'h80);
            push_byte(1'b0, 8'h7F);
            push_byte(1'b0, 8'h01);
            push_byte(1'b0, 8'hFE);
            push_byte(1'b1, 8'hFF);
            push_byte(1'b0, 8'hFF);
         end else if (phase % 2 == 1) begin
            // New registers must not touch the running stream until a restart.
            len = $urandom_range(3, 12);
            queue_buffer(1'b0, len);
            queued += len;
         end else if (phase == PHASE_COUNT - 2) begin
            // Long buffer: let the stream index wrap past the table size.
            queue_buffer(1'b1, 300);
            queued += 300;
         end

         // Mostly short well-formed buffers; some one-byte buffers and a few long.
         while (queued < 64) begin
            case ($urandom_range(0, 9))
               0:       len = $urandom_range(60, 120);
               1, 2:    len = 1;
               default: len = $urandom_range(2, 24);
            endcase
            queue_buffer(1'b1, len);
            queued += len;
         end

         wait_drained();
      end

      repeat (END_QUIET) @(posedge clock);

      $display("Sent %0d bytes in %0d buffers, checked %0d cipher bytes.",
               bytes_sent, buffer_starts, results_checked);
      $display("Six register sets: key lengths zero, one, full, saturated and random.");
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", failures);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/rc4iv_pkg.sv
rtl/core/rc4_iv_stream_cipher.sv
dv/rc4_iv_stream_cipher_test.sv
